// ----- rtl/core/sihf_pkg.sv -----
// Package for the serial image header framer.
// Holds the status and operation codes, register indexes and shared types.
// No dependencies.
package sihf_pkg;

  // Header layout: three little-endian 32-bit words.
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned HEADER_WORDS = 3;

  // Default largest payload that the receive buffer can take.
  localparam int unsigned PAYLOAD_LIMIT_DEFAULT = 65536;

  // Field widths.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned INDEX_W  = 8;

  // Register reset values.
  localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'hC0DE_FACE;
  localparam logic [WORD_W-1:0] FLOOR_RESET   = 32'h0020_0000;
  localparam logic [WORD_W-1:0] CEILING_RESET = 32'h0080_0000;
  localparam logic [SIZE_W-1:0] MAX_RESET     = 17'd65536;

  // Register indexes on the configuration channel.
  localparam logic [INDEX_W-1:0] CFG_MAGIC   = 8'd0;
  localparam logic [INDEX_W-1:0] CFG_FLOOR   = 8'd1;
  localparam logic [INDEX_W-1:0] CFG_CEILING = 8'd2;
  localparam logic [INDEX_W-1:0] CFG_MAX     = 8'd3;

  // Operation codes of an input request.
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Status codes of a result.
  typedef enum logic [3:0] {
    ST_IGNORED     = 4'd0,
    ST_ARMED       = 4'd1,
    ST_HEADER      = 4'd2,
    ST_PAYLOAD     = 4'd3,
    ST_COMPLETE    = 4'd4,
    ST_BAD_MAGIC   = 4'd5,
    ST_TOO_LARGE   = 4'd6,
    ST_BAD_ADDRESS = 4'd7,
    ST_OVERFLOW    = 4'd8
  } status_t;

  // Configuration registers as seen by the engine.
  typedef struct packed {
    logic [WORD_W-1:0] magic_word;
    logic [WORD_W-1:0] address_floor;
    logic [WORD_W-1:0] address_ceiling;
    logic [SIZE_W-1:0] max_payload;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_t           status;
    logic              write_enable;
    logic [WORD_W-1:0] write_address;
    logic [7:0]        write_data;
    logic [WORD_W-1:0] entry_address;
    logic [SIZE_W-1:0] payload_length;
  } result_t;

endpackage

// ----- rtl/core/sihf_cfg.sv -----
// Configuration register file of the serial image header framer.
// Depends on sihf_pkg for register indexes, reset values and cfg_t.
module sihf_cfg import sihf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  output cfg_t               cfg
);

  // Writes are always taken; the user must write only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word      <= MAGIC_RESET;
      cfg.address_floor   <= FLOOR_RESET;
      cfg.address_ceiling <= CEILING_RESET;
      cfg.max_payload     <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC:   cfg.magic_word      <= cfg_data;
        CFG_FLOOR:   cfg.address_floor   <= cfg_data;
        CFG_CEILING: cfg.address_ceiling <= cfg_data;
        CFG_MAX:     cfg.max_payload     <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sihf_engine.sv -----
// Load state and per-byte logic of the serial image header framer.
// Depends on sihf_pkg; computes one result per accepted request.
module sihf_engine import sihf_pkg::*; #(
  parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic       operation,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  localparam int unsigned CountW = $clog2(HEADER_BYTES + PAYLOAD_LIMIT + 1);
  localparam logic [CountW-1:0] BufferSize  = CountW'(HEADER_BYTES + PAYLOAD_LIMIT);
  localparam logic [CountW-1:0] HeaderCount = CountW'(HEADER_BYTES);
  localparam logic [CountW-1:0] HeaderLast  = CountW'(HEADER_BYTES - 1);

  logic              armed, armed_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [WORD_W-1:0] header_word      [HEADER_WORDS];
  logic [WORD_W-1:0] header_word_next [HEADER_WORDS];
  logic              header_ok, header_ok_next;

  logic [CountW-1:0] offset;
  logic [WORD_W-1:0] offset_ext;
  logic [3:0]        hdr_pos;

  assign offset     = byte_count - HeaderCount;
  assign offset_ext = WORD_W'(offset);
  assign hdr_pos    = byte_count[3:0];

  // Next state and result for the request on the input.
  always_comb begin
    armed_next       = armed;
    byte_count_next  = byte_count;
    header_word_next = header_word;
    header_ok_next   = header_ok;
    result.status        = ST_IGNORED;
    result.write_enable  = 1'b0;
    result.write_address = '0;
    result.write_data    = '0;

    if (operation == OP_ARM) begin
      // Arm clears the load and starts over.
      armed_next      = 1'b1;
      byte_count_next = '0;
      for (int w = 0; w < HEADER_WORDS; w++) begin
        header_word_next[w] = '0;
      end
      header_ok_next = 1'b0;
      result.status  = ST_ARMED;
    end else if (armed) begin
      if (byte_count >= BufferSize) begin
        // Buffer is full: the byte is dropped and the load ends.
        armed_next    = 1'b0;
        result.status = ST_OVERFLOW;
      end else if (byte_count < HeaderCount) begin
        // Header byte goes into its lane of the addressed word.
        for (int w = 0; w < HEADER_WORDS; w++) begin
          if (hdr_pos[3:2] == 2'(w)) begin
            header_word_next[w][{hdr_pos[1:0], 3'b000} +: 8] = data_byte;
          end
        end
        byte_count_next = byte_count + CountW'(1);
        result.status   = ST_HEADER;
        // Last header byte: magic, then size, then address window.
        if (byte_count == HeaderLast) begin
          if (header_word_next[0] != cfg.magic_word) begin
            armed_next    = 1'b0;
            result.status = ST_BAD_MAGIC;
          end else if (header_word_next[2] > WORD_W'(cfg.max_payload)) begin
            armed_next    = 1'b0;
            result.status = ST_TOO_LARGE;
          end else if (header_word_next[1] < cfg.address_floor ||
                       header_word_next[1] > cfg.address_ceiling) begin
            armed_next    = 1'b0;
            result.status = ST_BAD_ADDRESS;
          end else begin
            header_ok_next = 1'b1;
          end
        end
      end else begin
        // Payload byte becomes a memory write while inside the size.
        byte_count_next = byte_count + CountW'(1);
        result.status   = ST_PAYLOAD;
        if (offset_ext < header_word[2]) begin
          result.write_enable  = 1'b1;
          result.write_address = header_word[1] + offset_ext;
          result.write_data    = data_byte;
          if (offset_ext + 32'd1 == header_word[2]) begin
            armed_next    = 1'b0;
            result.status = ST_COMPLETE;
          end
        end
      end
    end

    result.entry_address  = header_ok_next ? header_word_next[1] : '0;
    result.payload_length = header_ok_next ? header_word_next[2][SIZE_W-1:0] : '0;
  end

  // Load state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      byte_count <= '0;
      for (int w = 0; w < HEADER_WORDS; w++) begin
        header_word[w] <= '0;
      end
      header_ok  <= 1'b0;
    end else if (advance) begin
      armed       <= armed_next;
      byte_count  <= byte_count_next;
      header_word <= header_word_next;
      header_ok   <= header_ok_next;
    end
  end

endmodule

// ----- rtl/core/sihf_out_reg.sv -----
// Result register of the serial image header framer.
// Depends on sihf_pkg for result_t; holds one result until it is taken.
module sihf_out_reg import sihf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t d,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t q
);

  // A new result may enter when the register is empty or being drained.
  assign in_ready = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ----- rtl/core/serial_image_header_framer.sv -----
// Top level of the serial image header framer.
// Depends on sihf_pkg, sihf_cfg, sihf_engine and sihf_out_reg.
//
// Usage: the input stream carries one request per byte. s_axis_tuser selects
// arm (0) or received byte (1); s_axis_tdata carries the byte. After an arm,
// twelve bytes form the header (magic, load address, size, little endian),
// then each payload byte comes out as a memory write request on the output
// stream, with the status code on m_axis_tuser.
// The configuration channel writes magic (0), address floor (1), address
// ceiling (2) and maximum payload (3); it is always ready. The user writes it
// only while no request is in flight; the block does not enforce this.
// The result of an accepted request is registered and shows in the next cycle.
// Throughput: one request per cycle; the per-byte count, header compare and
// address add sit between the input handshake and the result register.
// A stalled receiver holds the result register; s_axis_tready stays high as
// long as that register is empty or is drained in the same cycle.
// Reset: synchronous; the block comes up disarmed with counters and header
// cleared and registers at their defaults, with no clearing pass.
module serial_image_header_framer import sihf_pkg::*; #(
  parameter int unsigned PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte[7:0]
  input  logic [0:0]         s_axis_tuser,   // operation[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // write_enable[0], write_address[32:1], write_data[40:33],
  // entry_address[72:41], payload_length[89:73], zero pad[95:90]
  output logic [95:0]        m_axis_tdata,
  output logic [3:0]         m_axis_tuser,   // status[3:0]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t result;
  result_t held;
  logic    accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  sihf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sihf_engine #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .operation (s_axis_tuser[0]),
    .data_byte (s_axis_tdata),
    .cfg       (cfg),
    .result    (result)
  );

  sihf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .d         (result),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .q         (held)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tuser = held.status;
  assign m_axis_tdata = {6'b0, held.payload_length, held.entry_address,
                         held.write_data, held.write_address, held.write_enable};

`ifndef SYNTHESIS
  // An accepted arm request shows up as an armed result in the next cycle.
  a_arm_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tuser[0] == OP_ARM |=> m_axis_tvalid && m_axis_tuser == ST_ARMED)
    else $error("arm request did not give an armed result");

  // A memory write comes only with a payload or completion status.
  a_write_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tuser == ST_PAYLOAD || m_axis_tuser == ST_COMPLETE)
    else $error("write request with a non-payload status");

  // Completion always carries the last payload write.
  a_complete_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_COMPLETE |-> m_axis_tdata[0])
    else $error("completion without its payload write");
`endif

endmodule
